>>> sv/aabb_pkg.sv
// Package: item types, register indexes and the Q16.16 saturation helper.
package aabb_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned FracBits  = 16;
   localparam int unsigned ProdWidth = 2 * DataWidth;
   // three products plus the scaled translation, with margin
   localparam int unsigned SumWidth  = ProdWidth + 2;
   localparam int unsigned QuotWidth = SumWidth - FracBits;
   localparam int unsigned CsrIdxWidth = 3;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_LOCAL_MIN_X = 3'd0,
      CSR_LOCAL_MIN_Y = 3'd1,
      CSR_LOCAL_MIN_Z = 3'd2,
      CSR_LOCAL_MAX_X = 3'd3,
      CSR_LOCAL_MAX_Y = 3'd4,
      CSR_LOCAL_MAX_Z = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] m_r0c0;
      logic signed [DataWidth-1:0] m_r0c1;
      logic signed [DataWidth-1:0] m_r0c2;
      logic signed [DataWidth-1:0] m_r0c3;
      logic signed [DataWidth-1:0] m_r1c0;
      logic signed [DataWidth-1:0] m_r1c1;
      logic signed [DataWidth-1:0] m_r1c2;
      logic signed [DataWidth-1:0] m_r1c3;
      logic signed [DataWidth-1:0] m_r2c0;
      logic signed [DataWidth-1:0] m_r2c1;
      logic signed [DataWidth-1:0] m_r2c2;
      logic signed [DataWidth-1:0] m_r2c3;
   } req_data_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] world_min_x;
      logic signed [DataWidth-1:0] world_min_y;
      logic signed [DataWidth-1:0] world_min_z;
      logic signed [DataWidth-1:0] world_max_x;
      logic signed [DataWidth-1:0] world_max_y;
      logic signed [DataWidth-1:0] world_max_z;
   } rsp_data_type;

   // clamp a wide signed value into 32 bits
   function automatic logic signed [DataWidth-1:0] sat32(
      input logic signed [QuotWidth-1:0] q
   );
      logic signed [DataWidth-1:0] r;
      if (q[QuotWidth-1:DataWidth-1] == '0 || q[QuotWidth-1:DataWidth-1] == '1) begin
         r = q[DataWidth-1:0];
      end else if (q[QuotWidth-1]) begin
         r = {1'b1, {(DataWidth-1){1'b0}}};
      end else begin
         r = {1'b0, {(DataWidth-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

>>> sv/aabb_affine_transform_core.sv
// Affine transform of a configured local box into a world-space AABB.
// From accept (start && !busy) to the rsp_valid strobe an item passes these registers:
//   input reg, product reg, min/max select reg, result reg.
// Throughput: one item per cycle; busy stays low, set by the fully pipelined datapath.
// Results cannot be stalled; each is shown for exactly one cycle.
// Reset clears the valid pipeline and the six box registers to zero.
module aabb_affine_transform_core
   import aabb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_data_type           req_data,
   output logic                   rsp_valid,
   output rsp_data_type           rsp_data,
   input  logic                   csr_we,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [DataWidth-1:0]   csr_wdata
);

   logic                        accept;
   logic signed [DataWidth-1:0] box_lo_ff [3];
   logic signed [DataWidth-1:0] box_hi_ff [3];

   logic                        v0_ff, v1_ff, v2_ff, rsp_valid_ff;
   logic signed [DataWidth-1:0] mat_ff [3][4];
   logic signed [DataWidth-1:0] mat_in [3][4];

   logic signed [ProdWidth-1:0] plo_ff [3][3];
   logic signed [ProdWidth-1:0] phi_ff [3][3];
   logic signed [DataWidth-1:0] t1_ff  [3];

   logic signed [ProdWidth-1:0] smin_ff [3][3];
   logic signed [ProdWidth-1:0] smax_ff [3][3];
   logic signed [DataWidth-1:0] t2_ff   [3];

   logic signed [SumWidth-1:0]  sum_min [3];
   logic signed [SumWidth-1:0]  sum_max [3];
   logic signed [DataWidth-1:0] res_min [3];
   logic signed [DataWidth-1:0] res_max [3];
   rsp_data_type                rsp_data_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            box_lo_ff[a] <= '0;
            box_hi_ff[a] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOCAL_MIN_X: box_lo_ff[0] <= csr_wdata;
            CSR_LOCAL_MIN_Y: box_lo_ff[1] <= csr_wdata;
            CSR_LOCAL_MIN_Z: box_lo_ff[2] <= csr_wdata;
            CSR_LOCAL_MAX_X: box_hi_ff[0] <= csr_wdata;
            CSR_LOCAL_MAX_Y: box_hi_ff[1] <= csr_wdata;
            CSR_LOCAL_MAX_Z: box_hi_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      mat_in[0][0] = req_data.m_r0c0;
      mat_in[0][1] = req_data.m_r0c1;
      mat_in[0][2] = req_data.m_r0c2;
      mat_in[0][3] = req_data.m_r0c3;
      mat_in[1][0] = req_data.m_r1c0;
      mat_in[1][1] = req_data.m_r1c1;
      mat_in[1][2] = req_data.m_r1c2;
      mat_in[1][3] = req_data.m_r1c3;
      mat_in[2][0] = req_data.m_r2c0;
      mat_in[2][1] = req_data.m_r2c1;
      mat_in[2][2] = req_data.m_r2c2;
      mat_in[2][3] = req_data.m_r2c3;
   end

   // valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v0_ff        <= accept;
         v1_ff        <= v0_ff;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= v2_ff;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (accept) begin
         mat_ff <= mat_in;
      end
   end

   // products against both box bounds on each axis
   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         for (int a = 0; a < 3; a++) begin
            plo_ff[r][a] <= ProdWidth'(mat_ff[r][a]) * ProdWidth'(box_lo_ff[a]);
            phi_ff[r][a] <= ProdWidth'(mat_ff[r][a]) * ProdWidth'(box_hi_ff[a]);
         end
         t1_ff[r] <= mat_ff[r][3];
      end
   end

   // the corners span every combination, so the extreme corner picks each axis on its own
   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         for (int a = 0; a < 3; a++) begin
            if (plo_ff[r][a] <= phi_ff[r][a]) begin
               smin_ff[r][a] <= plo_ff[r][a];
               smax_ff[r][a] <= phi_ff[r][a];
            end else begin
               smin_ff[r][a] <= phi_ff[r][a];
               smax_ff[r][a] <= plo_ff[r][a];
            end
         end
         t2_ff[r] <= t1_ff[r];
      end
   end

   // exact sum, floor shift and clamp (both are monotonic, so min/max commute)
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sum_min[r] = SumWidth'(smin_ff[r][0]) + SumWidth'(smin_ff[r][1])
                    + SumWidth'(smin_ff[r][2])
                    + {{(SumWidth-DataWidth-FracBits){t2_ff[r][DataWidth-1]}},
                       t2_ff[r], {FracBits{1'b0}}};
         sum_max[r] = SumWidth'(smax_ff[r][0]) + SumWidth'(smax_ff[r][1])
                    + SumWidth'(smax_ff[r][2])
                    + {{(SumWidth-DataWidth-FracBits){t2_ff[r][DataWidth-1]}},
                       t2_ff[r], {FracBits{1'b0}}};
         res_min[r] = sat32(sum_min[r][SumWidth-1:FracBits]);
         res_max[r] = sat32(sum_max[r][SumWidth-1:FracBits]);
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff.world_min_x <= res_min[0];
      rsp_data_ff.world_min_y <= res_min[1];
      rsp_data_ff.world_min_z <= res_min[2];
      rsp_data_ff.world_max_x <= res_max[0];
      rsp_data_ff.world_max_y <= res_max[1];
      rsp_data_ff.world_max_z <= res_max[2];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_valid_advance: assert property (@(posedge clock) disable iff (reset)
      v2_ff |=> rsp_valid_ff)
      else $error("item lost in last stage");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !v2_ff |=> !rsp_valid_ff)
      else $error("result strobe without item");

   a_select_order: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> (smin_ff[0][0] <= smax_ff[0][0] && smin_ff[1][1] <= smax_ff[1][1]
                 && smin_ff[2][2] <= smax_ff[2][2]))
      else $error("min/max select inverted");

   a_world_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.world_min_x <= rsp_data_ff.world_max_x
                        && rsp_data_ff.world_min_y <= rsp_data_ff.world_max_y
                        && rsp_data_ff.world_min_z <= rsp_data_ff.world_max_z))
      else $error("world min exceeds max");

endmodule
